// ===== hw/rtl/cpe_pkg.sv =====
// cart-pole euler step: shared types, constants and the substep program
// no dependencies; used by every module of the block except cpe_checker
`default_nettype none
package cpe_pkg;

   localparam int WORD_W    = 32;
   localparam int FRAC_W    = 24;
   localparam int DIV_W     = WORD_W + FRAC_W;
   localparam int DIV_RADIX = 4;
   localparam int DIV_STEPS = DIV_W / DIV_RADIX;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int PC_W      = 7;
   localparam int SUB_W     = 7;

   localparam logic [PC_W-1:0] LAST_PC = PC_W'(70);

   localparam logic [WORD_W-1:0] ONE_Q     = WORD_W'(64'd16777216);
   localparam logic [WORD_W-1:0] PI_Q      = WORD_W'(64'd52707179);
   localparam logic [WORD_W-1:0] TWO_PI_Q  = WORD_W'(64'd105414358);
   localparam logic [WORD_W-1:0] HALF_PI_Q = WORD_W'(64'd26353589);
   localparam logic [WORD_W-1:0] ANGLE_RST = WORD_W'(64'd878452);

   localparam logic [30:0] GRAVITY_RST   = 31'd164577034;
   localparam logic [30:0] LENGTH_RST    = 31'd8388608;
   localparam logic [30:0] CART_MASS_RST = 31'd33554432;
   localparam logic [30:0] POLE_MASS_RST = 31'd3355443;
   localparam logic [24:0] DT_RST        = 25'd16777;
   localparam logic [6:0]  SUBSTEPS_RST  = 7'd10;
   localparam logic [30:0] FALL_RST      = 31'd8784522;

   typedef enum logic [2:0] {
      CSR_GRAVITY, CSR_POLE_LENGTH, CSR_CART_MASS, CSR_POLE_MASS,
      CSR_TIME_STEP, CSR_SUBSTEPS, CSR_FALL_LIMIT
   } csr_idx_type;

   typedef enum logic [2:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_FDIV, OP_IDIV, OP_MOD, OP_WRAP, OP_FOLD
   } op_type;

   typedef enum logic [4:0] {
      SEL_R, SEL_C, SEL_X2, SEL_T, SEL_ST, SEL_CT, SEL_W2, SEL_DEN,
      SEL_A, SEL_B, SEL_D, SEL_D2X, SEL_POS, SEL_VEL, SEL_ANG, SEL_RATE,
      SEL_G, SEL_L, SEL_MC, SEL_MP, SEL_DT, SEL_FORCE, SEL_ONE, SEL_ZERO,
      SEL_HALF_PI, SEL_TWO_PI, SEL_K110, SEL_K72, SEL_K42, SEL_K20, SEL_K6
   } opnd_type;

   typedef struct packed {
      op_type   op;
      opnd_type src_a;
      opnd_type src_b;
      opnd_type dst;
   } instr_type;

   typedef struct packed {
      logic      issue;
      logic      load;
      instr_type instr;
   } cmd_type;

   typedef struct packed {
      logic             done;
      logic [SUB_W-1:0] substeps;
   } stat_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_ISSUE, ST_WAIT, ST_RESULT
   } ctrl_state_type;

   function automatic instr_type mk(input op_type op, input opnd_type a,
                                    input opnd_type b, input opnd_type d);
      instr_type i;
      i.op    = op;
      i.src_a = a;
      i.src_b = b;
      i.dst   = d;
      return i;
   endfunction

   // one euler substep: angle reduction, sine and cosine series, motion
   // equations, then the state update
   function automatic instr_type prog_rom(input logic [PC_W-1:0] pc);
      instr_type i;
      case (pc)
         7'd0:  i = mk(OP_MOD,  SEL_ANG,  SEL_TWO_PI,  SEL_R);
         7'd1:  i = mk(OP_WRAP, SEL_R,    SEL_ZERO,    SEL_R);
         7'd2:  i = mk(OP_ADD,  SEL_R,    SEL_HALF_PI, SEL_C);
         7'd3:  i = mk(OP_WRAP, SEL_C,    SEL_ZERO,    SEL_C);
         7'd4:  i = mk(OP_FOLD, SEL_R,    SEL_ZERO,    SEL_R);
         7'd5:  i = mk(OP_FOLD, SEL_C,    SEL_ZERO,    SEL_C);
         7'd6:  i = mk(OP_MUL,  SEL_R,    SEL_R,       SEL_X2);
         7'd7:  i = mk(OP_IDIV, SEL_X2,   SEL_K110,    SEL_T);
         7'd8:  i = mk(OP_SUB,  SEL_ONE,  SEL_T,       SEL_T);
         7'd9:  i = mk(OP_MUL,  SEL_X2,   SEL_T,       SEL_T);
         7'd10: i = mk(OP_IDIV, SEL_T,    SEL_K72,     SEL_T);
         7'd11: i = mk(OP_SUB,  SEL_ONE,  SEL_T,       SEL_T);
         7'd12: i = mk(OP_MUL,  SEL_X2,   SEL_T,       SEL_T);
         7'd13: i = mk(OP_IDIV, SEL_T,    SEL_K42,     SEL_T);
         7'd14: i = mk(OP_SUB,  SEL_ONE,  SEL_T,       SEL_T);
         7'd15: i = mk(OP_MUL,  SEL_X2,   SEL_T,       SEL_T);
         7'd16: i = mk(OP_IDIV, SEL_T,    SEL_K20,     SEL_T);
         7'd17: i = mk(OP_SUB,  SEL_ONE,  SEL_T,       SEL_T);
         7'd18: i = mk(OP_MUL,  SEL_X2,   SEL_T,       SEL_T);
         7'd19: i = mk(OP_IDIV, SEL_T,    SEL_K6,      SEL_T);
         7'd20: i = mk(OP_SUB,  SEL_ONE,  SEL_T,       SEL_T);
         7'd21: i = mk(OP_MUL,  SEL_R,    SEL_T,       SEL_ST);
         7'd22: i = mk(OP_MUL,  SEL_C,    SEL_C,       SEL_X2);
         7'd23: i = mk(OP_IDIV, SEL_X2,   SEL_K110,    SEL_T);
         7'd24: i = mk(OP_SUB,  SEL_ONE,  SEL_T,       SEL_T);
         7'd25: i = mk(OP_MUL,  SEL_X2,   SEL_T,       SEL_T);
         7'd26: i = mk(OP_IDIV, SEL_T,    SEL_K72,     SEL_T);
         7'd27: i = mk(OP_SUB,  SEL_ONE,  SEL_T,       SEL_T);
         7'd28: i = mk(OP_MUL,  SEL_X2,   SEL_T,       SEL_T);
         7'd29: i = mk(OP_IDIV, SEL_T,    SEL_K42,     SEL_T);
         7'd30: i = mk(OP_SUB,  SEL_ONE,  SEL_T,       SEL_T);
         7'd31: i = mk(OP_MUL,  SEL_X2,   SEL_T,       SEL_T);
         7'd32: i = mk(OP_IDIV, SEL_T,    SEL_K20,     SEL_T);
         7'd33: i = mk(OP_SUB,  SEL_ONE,  SEL_T,       SEL_T);
         7'd34: i = mk(OP_MUL,  SEL_X2,   SEL_T,       SEL_T);
         7'd35: i = mk(OP_IDIV, SEL_T,    SEL_K6,      SEL_T);
         7'd36: i = mk(OP_SUB,  SEL_ONE,  SEL_T,       SEL_T);
         7'd37: i = mk(OP_MUL,  SEL_C,    SEL_T,       SEL_CT);
         7'd38: i = mk(OP_MUL,  SEL_RATE, SEL_RATE,    SEL_W2);
         7'd39: i = mk(OP_MUL,  SEL_ST,   SEL_ST,      SEL_A);
         7'd40: i = mk(OP_MUL,  SEL_MP,   SEL_A,       SEL_A);
         7'd41: i = mk(OP_ADD,  SEL_MC,   SEL_A,       SEL_A);
         7'd42: i = mk(OP_FDIV, SEL_ONE,  SEL_A,       SEL_DEN);
         7'd43: i = mk(OP_MUL,  SEL_L,    SEL_W2,      SEL_A);
         7'd44: i = mk(OP_MUL,  SEL_G,    SEL_CT,      SEL_B);
         7'd45: i = mk(OP_ADD,  SEL_A,    SEL_B,       SEL_A);
         7'd46: i = mk(OP_MUL,  SEL_MP,   SEL_ST,      SEL_B);
         7'd47: i = mk(OP_MUL,  SEL_B,    SEL_A,       SEL_B);
         7'd48: i = mk(OP_ADD,  SEL_FORCE, SEL_B,      SEL_B);
         7'd49: i = mk(OP_MUL,  SEL_DEN,  SEL_B,       SEL_D2X);
         7'd50: i = mk(OP_SUB,  SEL_ZERO, SEL_FORCE,   SEL_D);
         7'd51: i = mk(OP_MUL,  SEL_D,    SEL_CT,      SEL_D);
         7'd52: i = mk(OP_MUL,  SEL_MP,   SEL_L,       SEL_B);
         7'd53: i = mk(OP_MUL,  SEL_B,    SEL_W2,      SEL_B);
         7'd54: i = mk(OP_MUL,  SEL_B,    SEL_CT,      SEL_B);
         7'd55: i = mk(OP_MUL,  SEL_B,    SEL_ST,      SEL_B);
         7'd56: i = mk(OP_SUB,  SEL_D,    SEL_B,       SEL_D);
         7'd57: i = mk(OP_MUL,  SEL_MP,   SEL_MC,      SEL_B);
         7'd58: i = mk(OP_MUL,  SEL_B,    SEL_G,       SEL_B);
         7'd59: i = mk(OP_MUL,  SEL_B,    SEL_ST,      SEL_B);
         7'd60: i = mk(OP_ADD,  SEL_D,    SEL_B,       SEL_D);
         7'd61: i = mk(OP_FDIV, SEL_DEN,  SEL_L,       SEL_A);
         7'd62: i = mk(OP_MUL,  SEL_A,    SEL_D,       SEL_D);
         7'd63: i = mk(OP_MUL,  SEL_VEL,  SEL_DT,      SEL_A);
         7'd64: i = mk(OP_ADD,  SEL_POS,  SEL_A,       SEL_POS);
         7'd65: i = mk(OP_MUL,  SEL_RATE, SEL_DT,      SEL_A);
         7'd66: i = mk(OP_ADD,  SEL_ANG,  SEL_A,       SEL_ANG);
         7'd67: i = mk(OP_MUL,  SEL_D2X,  SEL_DT,      SEL_A);
         7'd68: i = mk(OP_ADD,  SEL_VEL,  SEL_A,       SEL_VEL);
         7'd69: i = mk(OP_MUL,  SEL_D,    SEL_DT,      SEL_A);
         7'd70: i = mk(OP_ADD,  SEL_RATE, SEL_A,       SEL_RATE);
         default: i = mk(OP_ADD, SEL_ZERO, SEL_ZERO,   SEL_T);
      endcase
      return i;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cpe_div.sv =====
// cart-pole euler step: radix-16 restoring divider, magnitudes only
// uses cpe_pkg for widths
`default_nettype none
module cpe_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [cpe_pkg::DIV_W-1:0]   dividend,
   input  wire logic [cpe_pkg::WORD_W-1:0]  divisor,
   output logic                             done,
   output logic [cpe_pkg::DIV_W-1:0]        quot,
   output logic [cpe_pkg::WORD_W-1:0]       rem
);
   logic [cpe_pkg::DIV_W-1:0]     quot_ff, quot_in;
   logic [cpe_pkg::WORD_W-1:0]    rem_ff, rem_in, divisor_ff;
   logic [cpe_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                          busy_ff, done_ff;
   logic                          last;

   assign last = (cnt_ff == cpe_pkg::DIV_CNT_W'(cpe_pkg::DIV_STEPS - 1));

   always_comb begin
      logic [cpe_pkg::WORD_W:0] t;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      for (int k = 0; k < cpe_pkg::DIV_RADIX; k++) begin
         t       = {rem_in, quot_in[cpe_pkg::DIV_W-1]};
         quot_in = {quot_in[cpe_pkg::DIV_W-2:0], 1'b0};
         if (t >= {1'b0, divisor_ff}) begin
            t          = t - {1'b0, divisor_ff};
            quot_in[0] = 1'b1;
         end
         rem_in = t[cpe_pkg::WORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff    <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last) busy_ff <= 1'b0;
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/cpe_ctrl.sv =====
// cart-pole euler step: controller, walks the substep program per command
// uses cpe_pkg for state, command and program types
`default_nettype none
module cpe_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output cpe_pkg::cmd_type       cmd,
   input  wire cpe_pkg::stat_type stat
);
   cpe_pkg::ctrl_state_type     state_ff, state_in;
   logic [cpe_pkg::PC_W-1:0]    pc_ff, pc_in;
   logic [cpe_pkg::SUB_W-1:0]   sub_ff, sub_in;
   logic                        accept, sub_last;

   assign accept   = req_valid && (state_ff == cpe_pkg::ST_IDLE);
   assign sub_last = ({1'b0, sub_ff} + 1'b1) == {1'b0, stat.substeps};

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      sub_in   = sub_ff;
      case (state_ff)
         cpe_pkg::ST_IDLE: begin
            if (accept) begin
               pc_in    = '0;
               sub_in   = '0;
               state_in = (stat.substeps == '0) ? cpe_pkg::ST_RESULT : cpe_pkg::ST_ISSUE;
            end
         end
         cpe_pkg::ST_ISSUE: state_in = cpe_pkg::ST_WAIT;
         cpe_pkg::ST_WAIT: begin
            if (stat.done) begin
               if (pc_ff == cpe_pkg::LAST_PC) begin
                  pc_in = '0;
                  if (sub_last) begin
                     state_in = cpe_pkg::ST_RESULT;
                  end else begin
                     sub_in   = sub_ff + 1'b1;
                     state_in = cpe_pkg::ST_ISSUE;
                  end
               end else begin
                  pc_in    = pc_ff + 1'b1;
                  state_in = cpe_pkg::ST_ISSUE;
               end
            end
         end
         cpe_pkg::ST_RESULT: begin
            if (!rsp_stall) state_in = cpe_pkg::ST_IDLE;
         end
         default: state_in = cpe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.issue = (state_ff == cpe_pkg::ST_ISSUE);
      cmd.load  = accept;
      cmd.instr = cpe_pkg::prog_rom(pc_ff);
      req_stall = (state_ff != cpe_pkg::ST_IDLE);
      rsp_valid = (state_ff == cpe_pkg::ST_RESULT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpe_pkg::ST_IDLE;
         pc_ff    <= '0;
         sub_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         sub_ff   <= sub_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/cpe_datapath.sv =====
// cart-pole euler step: datapath with settings, plant state, scratch
// registers, shared multiplier and shared divider; uses cpe_pkg, cpe_div
`default_nettype none
module cpe_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [2:0]                   csr_index,
   input  wire logic [30:0]                  csr_wdata,
   input  wire logic signed [31:0]           force_req,
   input  wire cpe_pkg::cmd_type             cmd,
   output cpe_pkg::stat_type                 stat,
   output logic [cpe_pkg::WORD_W-1:0]        position,
   output logic [cpe_pkg::WORD_W-1:0]        velocity,
   output logic [cpe_pkg::WORD_W-1:0]        angle,
   output logic [cpe_pkg::WORD_W-1:0]        angular_rate,
   output logic                              fallen
);
   localparam int W = cpe_pkg::WORD_W;

   logic [30:0] g_ff, l_ff, mc_ff, mp_ff, fall_ff;
   logic [24:0] dt_ff;
   logic [6:0]  nsub_ff;

   logic [W-1:0] pos_ff, vel_ff, ang_ff, rate_ff, force_ff;
   logic [W-1:0] r_ff, c_ff, x2_ff, t_ff, st_ff, ct_ff, w2_ff, den_ff;
   logic [W-1:0] a_ff, b_ff, d_ff, d2x_ff;

   logic [W-1:0]        opa_ff, opb_ff;
   cpe_pkg::op_type     op_ff;
   cpe_pkg::opnd_type   dst_ff;
   logic                run_ff, mul_ph_ff, div_sent_ff;
   logic [2*W-1:0]      prod_ff;

   logic [W-1:0]              mag_a, mag_b, res_in;
   logic                      neg, wr_en, div_start, div_done;
   logic [cpe_pkg::DIV_W-1:0] div_dividend, div_quot;
   logic [W-1:0]              div_rem;

   function automatic logic [W-1:0] mag(input logic [W-1:0] v);
      return v[W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [W-1:0] sres(input logic n,
                                          input logic [cpe_pkg::DIV_W-1:0] m);
      logic [cpe_pkg::DIV_W-1:0] lim, mm;
      logic [W-1:0]              r;
      lim = n ? (cpe_pkg::DIV_W'(1) << (W - 1)) : ((cpe_pkg::DIV_W'(1) << (W - 1)) - 1'b1);
      mm  = (m > lim) ? lim : m;
      r   = mm[W-1:0];
      return n ? (~r + 1'b1) : r;
   endfunction

   function automatic logic [W-1:0] sat_sum(input logic [W:0] s);
      if (s[W] != s[W-1]) return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] opnd_val(input cpe_pkg::opnd_type s);
      case (s)
         cpe_pkg::SEL_R:       return r_ff;
         cpe_pkg::SEL_C:       return c_ff;
         cpe_pkg::SEL_X2:      return x2_ff;
         cpe_pkg::SEL_T:       return t_ff;
         cpe_pkg::SEL_ST:      return st_ff;
         cpe_pkg::SEL_CT:      return ct_ff;
         cpe_pkg::SEL_W2:      return w2_ff;
         cpe_pkg::SEL_DEN:     return den_ff;
         cpe_pkg::SEL_A:       return a_ff;
         cpe_pkg::SEL_B:       return b_ff;
         cpe_pkg::SEL_D:       return d_ff;
         cpe_pkg::SEL_D2X:     return d2x_ff;
         cpe_pkg::SEL_POS:     return pos_ff;
         cpe_pkg::SEL_VEL:     return vel_ff;
         cpe_pkg::SEL_ANG:     return ang_ff;
         cpe_pkg::SEL_RATE:    return rate_ff;
         cpe_pkg::SEL_G:       return {1'b0, g_ff};
         cpe_pkg::SEL_L:       return {1'b0, l_ff};
         cpe_pkg::SEL_MC:      return {1'b0, mc_ff};
         cpe_pkg::SEL_MP:      return {1'b0, mp_ff};
         cpe_pkg::SEL_DT:      return {7'b0, dt_ff};
         cpe_pkg::SEL_FORCE:   return force_ff;
         cpe_pkg::SEL_ONE:     return cpe_pkg::ONE_Q;
         cpe_pkg::SEL_ZERO:    return '0;
         cpe_pkg::SEL_HALF_PI: return cpe_pkg::HALF_PI_Q;
         cpe_pkg::SEL_TWO_PI:  return cpe_pkg::TWO_PI_Q;
         cpe_pkg::SEL_K110:    return W'(110);
         cpe_pkg::SEL_K72:     return W'(72);
         cpe_pkg::SEL_K42:     return W'(42);
         cpe_pkg::SEL_K20:     return W'(20);
         cpe_pkg::SEL_K6:      return W'(6);
         default:              return '0;
      endcase
   endfunction

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         g_ff    <= cpe_pkg::GRAVITY_RST;
         l_ff    <= cpe_pkg::LENGTH_RST;
         mc_ff   <= cpe_pkg::CART_MASS_RST;
         mp_ff   <= cpe_pkg::POLE_MASS_RST;
         dt_ff   <= cpe_pkg::DT_RST;
         nsub_ff <= cpe_pkg::SUBSTEPS_RST;
         fall_ff <= cpe_pkg::FALL_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            cpe_pkg::CSR_GRAVITY:     g_ff    <= csr_wdata;
            cpe_pkg::CSR_POLE_LENGTH: l_ff    <= csr_wdata;
            cpe_pkg::CSR_CART_MASS:   mc_ff   <= csr_wdata;
            cpe_pkg::CSR_POLE_MASS:   mp_ff   <= csr_wdata;
            cpe_pkg::CSR_TIME_STEP:   dt_ff   <= csr_wdata[24:0];
            cpe_pkg::CSR_SUBSTEPS:    nsub_ff <= csr_wdata[6:0];
            cpe_pkg::CSR_FALL_LIMIT:  fall_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign mag_a = mag(opa_ff);
   assign mag_b = mag(opb_ff);
   assign neg   = opa_ff[W-1] ^ opb_ff[W-1];

   assign div_dividend = (op_ff == cpe_pkg::OP_FDIV)
                         ? {mag_a, {cpe_pkg::FRAC_W{1'b0}}}
                         : {{cpe_pkg::FRAC_W{1'b0}}, mag_a};

   cpe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (mag_b),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // operation result for the cycle in which it is written back, with the write enable and the divider start
   always_comb begin
      logic [2*W-1:0] rnd;
      logic [W:0]     ext;
      rnd       = prod_ff + (2*W)'(1 << (cpe_pkg::FRAC_W - 1));
      ext       = {opa_ff[W-1], opa_ff};
      res_in    = opa_ff;
      wr_en     = 1'b0;
      div_start = 1'b0;
      case (op_ff)
         cpe_pkg::OP_ADD: res_in = sat_sum(ext + {opb_ff[W-1], opb_ff});
         cpe_pkg::OP_SUB: res_in = sat_sum(ext - {opb_ff[W-1], opb_ff});
         cpe_pkg::OP_MUL:
            res_in = sres(neg, cpe_pkg::DIV_W'(rnd >> cpe_pkg::FRAC_W));
         cpe_pkg::OP_FDIV: begin
            if (mag_b == '0)
               res_in = opa_ff[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            else
               res_in = sres(neg, div_quot);
         end
         cpe_pkg::OP_IDIV: res_in = sres(neg, div_quot);
         cpe_pkg::OP_MOD:  res_in = opa_ff[W-1] ? (~div_rem + 1'b1) : div_rem;
         cpe_pkg::OP_WRAP: begin
            if ($signed(opa_ff) > $signed(cpe_pkg::PI_Q))
               res_in = opa_ff - cpe_pkg::TWO_PI_Q;
            else if ($signed(opa_ff) < -$signed(cpe_pkg::PI_Q))
               res_in = opa_ff + cpe_pkg::TWO_PI_Q;
         end
         cpe_pkg::OP_FOLD: begin
            if ($signed(opa_ff) > $signed(cpe_pkg::HALF_PI_Q))
               res_in = cpe_pkg::PI_Q - opa_ff;
            else if ($signed(opa_ff) < -$signed(cpe_pkg::HALF_PI_Q))
               res_in = -cpe_pkg::PI_Q - opa_ff;
         end
         default: res_in = opa_ff;
      endcase
      if (run_ff) begin
         case (op_ff)
            cpe_pkg::OP_MUL: wr_en = mul_ph_ff;
            cpe_pkg::OP_FDIV, cpe_pkg::OP_IDIV, cpe_pkg::OP_MOD: begin
               div_start = !div_sent_ff;
               wr_en     = div_done;
            end
            default: wr_en = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mag_a * mag_b;
      if (cmd.issue) begin
         opa_ff <= opnd_val(cmd.instr.src_a);
         opb_ff <= opnd_val(cmd.instr.src_b);
         op_ff  <= cmd.instr.op;
         dst_ff <= cmd.instr.dst;
      end
      if (cmd.load) force_ff <= force_req;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         mul_ph_ff   <= 1'b0;
         div_sent_ff <= 1'b0;
      end else if (cmd.issue) begin
         run_ff      <= 1'b1;
         mul_ph_ff   <= 1'b0;
         div_sent_ff <= 1'b0;
      end else if (wr_en) begin
         run_ff <= 1'b0;
      end else begin
         if (run_ff && op_ff == cpe_pkg::OP_MUL) mul_ph_ff <= 1'b1;
         if (div_start) div_sent_ff <= 1'b1;
      end
   end

   // scratch registers
   always_ff @(posedge clock) begin
      if (wr_en) begin
         case (dst_ff)
            cpe_pkg::SEL_R:   r_ff   <= res_in;
            cpe_pkg::SEL_C:   c_ff   <= res_in;
            cpe_pkg::SEL_X2:  x2_ff  <= res_in;
            cpe_pkg::SEL_T:   t_ff   <= res_in;
            cpe_pkg::SEL_ST:  st_ff  <= res_in;
            cpe_pkg::SEL_CT:  ct_ff  <= res_in;
            cpe_pkg::SEL_W2:  w2_ff  <= res_in;
            cpe_pkg::SEL_DEN: den_ff <= res_in;
            cpe_pkg::SEL_A:   a_ff   <= res_in;
            cpe_pkg::SEL_B:   b_ff   <= res_in;
            cpe_pkg::SEL_D:   d_ff   <= res_in;
            cpe_pkg::SEL_D2X: d2x_ff <= res_in;
            default: ;
         endcase
      end
   end

   // plant state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         vel_ff  <= '0;
         ang_ff  <= cpe_pkg::ANGLE_RST;
         rate_ff <= '0;
      end else if (wr_en) begin
         case (dst_ff)
            cpe_pkg::SEL_POS:  pos_ff  <= res_in;
            cpe_pkg::SEL_VEL:  vel_ff  <= res_in;
            cpe_pkg::SEL_ANG:  ang_ff  <= res_in;
            cpe_pkg::SEL_RATE: rate_ff <= res_in;
            default: ;
         endcase
      end
   end

   assign stat.done     = wr_en;
   assign stat.substeps = nsub_ff;

   assign position     = pos_ff;
   assign velocity     = vel_ff;
   assign angle        = ang_ff;
   assign angular_rate = rate_ff;
   assign fallen       = mag(ang_ff) > {1'b0, fall_ff};
endmodule
`default_nettype wire

// ===== hw/rtl/cart_pole_euler_step.sv =====
// cart-pole euler step, top level: controller plus datapath
// work per euler substep: 13 divides on the shared radix-16 divider and 33 multiplies
// throughput: one command at a time; the next is taken once the result transfers
// reset: synchronous, restores settings to defaults and the plant to rest at 3 degrees
// uses cpe_pkg, cpe_ctrl, cpe_datapath
`default_nettype none
module cart_pole_euler_step (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [30:0]        csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_force_req,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_position,
   output logic signed [31:0]      rsp_velocity,
   output logic signed [31:0]      rsp_angle,
   output logic signed [31:0]      rsp_angular_rate,
   output logic                    rsp_fallen
);
   cpe_pkg::cmd_type  cmd;
   cpe_pkg::stat_type stat;

   cpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   cpe_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .force_req    (req_force_req),
      .cmd          (cmd),
      .stat         (stat),
      .position     (rsp_position),
      .velocity     (rsp_velocity),
      .angle        (rsp_angle),
      .angular_rate (rsp_angular_rate),
      .fallen       (rsp_fallen)
   );
endmodule
`default_nettype wire

// ===== hw/rtl/cpe_checker.sv =====
// cart-pole euler step: port-level checker and its bind to the top level
// depends on the top level's ports only
`default_nettype none
module cpe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        csr_wr_en,
   input wire logic [2:0]  csr_index,
   input wire logic [30:0] csr_wdata,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [31:0] req_force_req,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_position,
   input wire logic [31:0] rsp_velocity,
   input wire logic [31:0] rsp_angle,
   input wire logic [31:0] rsp_angular_rate,
   input wire logic        rsp_fallen
);
   // a pending result holds until it transfers
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position)
         && $stable(rsp_angle) && $stable(rsp_fallen))
      else $error("result changed while stalled");

   // one command in flight: a transfer in closes the input side
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second command taken while busy");

   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result waits");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("block not idle after reset");
endmodule

bind cart_pole_euler_step cpe_checker u_cpe_checker (.*);
`default_nettype wire

// ===== tb/sv/cart_pole_euler_step_tb.sv =====
// testbench for cart_pole_euler_step: directed stimulus table, then randomised phases of
// force commands under changing plant settings, checked against a fixed-point plant predictor
// depends on cpe_pkg and the cart_pole_euler_step rtl
`default_nettype none
module cart_pole_euler_step_tb;
   import cpe_pkg::*;

   localparam longint LIMIT_CYCLES = 64'd30000000;
   localparam int     RANDOM_ITEMS = 600;
   localparam longint MAXV  = 64'sd2147483647;
   localparam longint MINV  = -64'sd2147483648;
   localparam longint ONE_V = longint'(ONE_Q);
   localparam longint PI_V  = longint'(PI_Q);
   localparam longint TWO_PI_V  = longint'(TWO_PI_Q);
   localparam longint HALF_PI_V = longint'(HALF_PI_Q);
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [31:0] angle;
      logic signed [31:0] angular_rate;
      logic               fallen;
   } plant_state_type;

   typedef struct {
      row_kind_type    kind;
      logic [2:0]      index;
      logic [30:0]     wdata;
      logic [31:0]     force_val;
      logic            typed;
      plant_state_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [2:0] csr_index;
   logic [30:0] csr_wdata;
   logic req_valid, req_stall;
   logic signed [31:0] req_force_req;
   logic rsp_valid, rsp_stall;
   logic signed [31:0] rsp_position, rsp_velocity, rsp_angle, rsp_angular_rate;
   logic rsp_fallen;

   plant_state_type plant_q[$];
   longint settings[7];
   longint pos_s, vel_s, ang_s, rate_s;
   int     fail_count = 0;
   longint cycle_count = 0;
   logic   quiet = 1'b0;
   stim_row_type stim_rows[$];

   cart_pole_euler_step DUT (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_force_req(req_force_req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_position(rsp_position), .rsp_velocity(rsp_velocity), .rsp_angle(rsp_angle),
      .rsp_angular_rate(rsp_angular_rate), .rsp_fallen(rsp_fallen)
   );

   always #2 clock = ~clock;

   // fixed-point arithmetic of the plant
   function automatic longint sat(input longint v);
      if (v > MAXV) return MAXV;
      if (v < MINV) return MINV;
      return v;
   endfunction

   function automatic longint unsigned magn(input longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint signed_mag(input logic neg, input longint unsigned m);
      longint unsigned lim;
      lim = neg ? 64'd2147483648 : 64'd2147483647;
      if (m > lim) m = lim;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      longint unsigned p;
      p = magn(a) * magn(b);
      p = (p + 64'd8388608) >> 24;
      return signed_mag((a < 0) != (b < 0), p);
   endfunction

   function automatic longint qdiv(input longint a, input longint b);
      longint unsigned ua, ub;
      ua = magn(a);
      ub = magn(b);
      if (ub == 0) return a < 0 ? MINV : MAXV;
      return signed_mag((a < 0) != (b < 0), (ua << 24) / ub);
   endfunction

   function automatic longint wrap_angle(input longint x);
      longint r;
      r = x % TWO_PI_V;
      if (r > PI_V) r -= TWO_PI_V;
      if (r < -PI_V) r += TWO_PI_V;
      return r;
   endfunction

   function automatic longint qsin(input longint x);
      longint r, x2, t;
      r = wrap_angle(x);
      if (r > HALF_PI_V) r = PI_V - r;
      if (r < -HALF_PI_V) r = -PI_V - r;
      x2 = qmul(r, r);
      t = sat(ONE_V - x2 / 110);
      t = sat(ONE_V - qmul(x2, t) / 72);
      t = sat(ONE_V - qmul(x2, t) / 42);
      t = sat(ONE_V - qmul(x2, t) / 20);
      t = sat(ONE_V - qmul(x2, t) / 6);
      return qmul(r, t);
   endfunction

   // advances the plant by one force command and returns the reported state
   function automatic plant_state_type advance_plant(input logic signed [31:0] f_in);
      plant_state_type o;
      longint f, g, l, mc, mp, dt, w2, st, ct, den, inner, d2x, ta, tb, tc, d2t;
      f  = longint'(f_in);
      g  = settings[CSR_GRAVITY];
      l  = settings[CSR_POLE_LENGTH];
      mc = settings[CSR_CART_MASS];
      mp = settings[CSR_POLE_MASS];
      dt = settings[CSR_TIME_STEP];
      for (longint k = 0; k < settings[CSR_SUBSTEPS]; k++) begin
         w2    = qmul(rate_s, rate_s);
         st    = qsin(ang_s);
         ct    = qsin(wrap_angle(ang_s) + HALF_PI_V);
         den   = qdiv(ONE_V, sat(mc + qmul(mp, qmul(st, st))));
         inner = sat(qmul(l, w2) + qmul(g, ct));
         d2x   = qmul(den, sat(f + qmul(qmul(mp, st), inner)));
         ta    = qmul(sat(-f), ct);
         tb    = qmul(qmul(qmul(qmul(mp, l), w2), ct), st);
         tc    = qmul(qmul(qmul(mp, mc), g), st);
         d2t   = qmul(qdiv(den, l), sat(sat(ta - tb) + tc));
         pos_s  = sat(pos_s + qmul(vel_s, dt));
         ang_s  = sat(ang_s + qmul(rate_s, dt));
         vel_s  = sat(vel_s + qmul(d2x, dt));
         rate_s = sat(rate_s + qmul(d2t, dt));
      end
      o.position     = pos_s[31:0];
      o.velocity     = vel_s[31:0];
      o.angle        = ang_s[31:0];
      o.angular_rate = rate_s[31:0];
      o.fallen       = magn(ang_s) > settings[CSR_FALL_LIMIT];
      return o;
   endfunction

   function automatic plant_state_type st_of(input logic signed [31:0] p, v, a, r,
                                             input logic fl);
      plant_state_type s;
      s.position = p; s.velocity = v; s.angle = a; s.angular_rate = r; s.fallen = fl;
      return s;
   endfunction

   function automatic stim_row_type csr_row(input logic [2:0] idx, input logic [30:0] d);
      stim_row_type r;
      r = '{kind: ROW_CSR, index: idx, wdata: d, force_val: 0, typed: 0, want: st_of(0,0,0,0,0)};
      return r;
   endfunction

   function automatic stim_row_type item_row(input logic [31:0] f, input logic typed,
                                             input plant_state_type w);
      stim_row_type r;
      r = '{kind: ROW_ITEM, index: 0, wdata: 0, force_val: f, typed: typed, want: w};
      return r;
   endfunction

   // sender: valid is only lowered when a gap is taken, so back-to-back transfers keep it high
   task automatic send_force(input logic [31:0] f, input logic typed,
                             input plant_state_type want);
      plant_state_type p;
      while (!quiet && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_force_req <= f;
      do @(posedge clock); while (req_stall);
      p = advance_plant(f);
      plant_q.push_back(typed ? want : p);
   endtask

   // settings change only once the block has drained
   task automatic write_setting(input logic [2:0] idx, input logic [30:0] d);
      req_valid <= 1'b0;
      do @(posedge clock); while (plant_q.size() != 0);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_TIME_STEP: settings[idx] = d & 31'h1FFFFFF;
         CSR_SUBSTEPS:  settings[idx] = d & 31'h7F;
         CSR_UNUSED:    ;
         default:       settings[idx] = d;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet && $urandom_range(99) < 11;
      end
   end

   always @(posedge clock) begin
      plant_state_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (plant_q.size() == 0) begin
            $error("result transfer with nothing expected");
            fail_count++;
         end else begin
            w = plant_q.pop_front();
            if (rsp_position !== w.position) begin
               $error("position expected %0d actual %0d", w.position, rsp_position);
               fail_count++;
            end
            if (rsp_velocity !== w.velocity) begin
               $error("velocity expected %0d actual %0d", w.velocity, rsp_velocity);
               fail_count++;
            end
            if (rsp_angle !== w.angle) begin
               $error("angle expected %0d actual %0d", w.angle, rsp_angle);
               fail_count++;
            end
            if (rsp_angular_rate !== w.angular_rate) begin
               $error("angular_rate expected %0d actual %0d", w.angular_rate,
                      rsp_angular_rate);
               fail_count++;
            end
            if (rsp_fallen !== w.fallen) begin
               $error("fallen expected %0d actual %0d", w.fallen, rsp_fallen);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      plant_state_type rest, none;
      logic [31:0] f;
      int sent, phase_len;
      reset         <= 1'b1;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_GRAVITY;
      csr_wdata     <= '0;
      req_valid     <= 1'b0;
      req_force_req <= '0;
      settings = '{164577034, 8388608, 33554432, 3355443, 16777, 10, 8784522};
      pos_s = 0; vel_s = 0; ang_s = longint'(ANGLE_RST); rate_s = 0;
      rest = st_of(0, 0, 878452, 0, 1'b0);
      none = st_of(0, 0, 0, 0, 1'b0);

      // zero substeps leave the plant at rest; later rows hit the extremes
      stim_rows.push_back(csr_row(CSR_SUBSTEPS, 0));
      stim_rows.push_back(item_row(32'h0, 1, rest));
      stim_rows.push_back(item_row(32'h7FFFFFFF, 1, rest));
      stim_rows.push_back(item_row(32'h80000000, 1, rest));
      stim_rows.push_back(csr_row(CSR_FALL_LIMIT, 0));
      stim_rows.push_back(item_row(32'h1, 1, st_of(0, 0, 878452, 0, 1'b1)));
      stim_rows.push_back(csr_row(CSR_FALL_LIMIT, 31'd8784522));
      stim_rows.push_back(csr_row(CSR_SUBSTEPS, 10));
      stim_rows.push_back(item_row(32'd16777216, 0, none));
      stim_rows.push_back(item_row(-32'sd16777216, 0, none));
      stim_rows.push_back(csr_row(CSR_POLE_LENGTH, 0));
      stim_rows.push_back(item_row(32'd3000000, 0, none));
      stim_rows.push_back(csr_row(CSR_POLE_LENGTH, 31'd8388608));
      stim_rows.push_back(csr_row(CSR_CART_MASS, 0));
      stim_rows.push_back(csr_row(CSR_POLE_MASS, 0));
      stim_rows.push_back(item_row(32'd5, 0, none));
      stim_rows.push_back(item_row(32'h0, 0, none));
      stim_rows.push_back(csr_row(CSR_UNUSED, 31'h7FFFFFFF));
      stim_rows.push_back(item_row(-32'sd100, 0, none));
      stim_rows.push_back(csr_row(CSR_GRAVITY, 31'h7FFFFFFF));
      stim_rows.push_back(csr_row(CSR_CART_MASS, 31'h7FFFFFFF));
      stim_rows.push_back(csr_row(CSR_POLE_MASS, 31'h7FFFFFFF));
      stim_rows.push_back(csr_row(CSR_TIME_STEP, 31'h1FFFFFF));
      stim_rows.push_back(csr_row(CSR_SUBSTEPS, 1));
      stim_rows.push_back(item_row(32'h7FFFFFFF, 0, none));
      stim_rows.push_back(item_row(32'h80000000, 0, none));
      stim_rows.push_back(csr_row(CSR_SUBSTEPS, 127));
      stim_rows.push_back(item_row(32'h12345678, 0, none));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR)
            write_setting(stim_rows[i].index, stim_rows[i].wdata);
         else
            send_force(stim_rows[i].force_val, stim_rows[i].typed, stim_rows[i].want);
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // each phase drains, picks plant settings, then runs a burst of commands
         if ($urandom_range(99) < 70) begin
            write_setting(CSR_GRAVITY, $urandom_range(32'd200000000));
            write_setting(CSR_POLE_LENGTH, $urandom_range(32'd50000000, 32'd1000000));
            write_setting(CSR_CART_MASS, $urandom_range(32'd80000000, 32'd4000000));
            write_setting(CSR_POLE_MASS, $urandom_range(32'd20000000));
            write_setting(CSR_TIME_STEP, $urandom_range(32'd400000, 1));
            write_setting(CSR_FALL_LIMIT, $urandom_range(32'd30000000));
         end else begin
            write_setting(CSR_GRAVITY, $urandom());
            write_setting(CSR_POLE_LENGTH, $urandom());
            write_setting(CSR_CART_MASS, $urandom());
            write_setting(CSR_POLE_MASS, $urandom());
            write_setting(CSR_TIME_STEP, $urandom());
            write_setting(CSR_FALL_LIMIT, $urandom());
         end
         write_setting(CSR_SUBSTEPS, ($urandom_range(99) < 4) ? 64 : $urandom_range(4));
         if ($urandom_range(99) < 10) write_setting(CSR_UNUSED, $urandom());
         phase_len = $urandom_range(40, 15);
         for (int j = 0; j < phase_len && sent < RANDOM_ITEMS; j++) begin
            quiet = (sent >= 200 && sent < 320);
            if ($urandom_range(99) < 65)
               f = $signed($urandom_range(32'd200000000)) - 32'sd100000000;
            else
               f = $urandom();
            send_force(f, 1'b0, none);
            sent++;
         end
      end

      quiet = 1'b0;
      req_valid <= 1'b0;
      do @(posedge clock); while (plant_q.size() != 0);
      repeat (1000) @(posedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/cpe_pkg.sv
hw/rtl/cpe_div.sv
hw/rtl/cpe_ctrl.sv
hw/rtl/cpe_datapath.sv
hw/rtl/cart_pole_euler_step.sv
hw/rtl/cpe_checker.sv
tb/sv/cart_pole_euler_step_tb.sv
